### rtl/swmm_pkg.sv
// Package for the sliding-window minimum and maximum block.
// Holds the sample type and the default window depth; depends on nothing.
package swmm_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned WINDOW_DEF = 64;

  typedef logic [DATA_W-1:0] data_t;

endpackage

### rtl/swmm_in_if.sv
// Input stream interface: one sample per beat.
// Depends on swmm_pkg for the sample type.
interface swmm_in_if;
  import swmm_pkg::*;

  logic  valid;
  logic  ready;
  data_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### rtl/swmm_out_if.sv
// Result stream interface: window minimum and maximum per beat.
// Depends on swmm_pkg for the sample type.
interface swmm_out_if;
  import swmm_pkg::*;

  logic  valid;
  logic  ready;
  data_t current_min;
  data_t current_max;

  modport source (output valid, output current_min, output current_max, input ready);
  modport sink   (input valid, input current_min, input current_max, output ready);
endinterface

### rtl/swmm_ram.sv
// Sample ring storage: one write port and one read port, read data registered.
// Depends on swmm_pkg for the sample type.
module swmm_ram #(
  parameter int unsigned DEPTH = swmm_pkg::WINDOW_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  swmm_pkg::data_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output swmm_pkg::data_t rdata_o
);
  import swmm_pkg::*;

  data_t mem [DEPTH];
  data_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sliding_window_min_max.sv
// Sliding-window minimum and maximum over the last WINDOW samples.
// Each accepted sample evicts the oldest ring entry and the result is pushed out;
// when the evicted sample was an extreme, the single read port first rescans the whole
// ring. One item at a time: no new sample is taken until the last result is pushed.
// Reset clears the index, extremes and fill flag; the ring memory is not swept,
// entries not yet written read as zero through the fill flag and write index.
module sliding_window_min_max #(
  parameter int unsigned WINDOW = swmm_pkg::WINDOW_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  swmm_in_if.sink   in_i,
  swmm_out_if.source out_o
);
  import swmm_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_SCAN,
    ST_DRAIN,
    ST_PUSH
  } state_e;

  state_e        state_q;
  logic [AW-1:0] wr_idx_q;
  logic          full_q;
  logic [AW-1:0] scan_addr_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  data_t         sample_q;
  data_t         held_min_q;
  data_t         held_max_q;
  logic          out_vld_q;
  data_t         out_min_q;
  data_t         out_max_q;

  logic          in_fire;
  logic          push_fire;
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  data_t         ram_rdata;
  data_t         evicted;
  data_t         new_min;
  data_t         new_max;
  logic          need_scan;
  data_t         scan_val;
  logic          wr_last;

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign push_fire = (state_q == ST_PUSH) && (!out_vld_q || out_o.ready);

  assign ram_we    = (state_q == ST_EVICT);
  assign ram_re    = in_fire || (state_q == ST_SCAN);
  assign ram_raddr = (state_q == ST_SCAN) ? scan_addr_q : wr_idx_q;

  swmm_ram #(
    .DEPTH (WINDOW),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (sample_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Until the ring has wrapped once, the entry under the write index was never written.
  assign evicted   = full_q ? ram_rdata : '0;
  assign new_min   = (sample_q < held_min_q) ? sample_q : held_min_q;
  assign new_max   = (sample_q > held_max_q) ? sample_q : held_max_q;
  assign need_scan = (new_min == evicted) || (new_max == evicted);
  assign wr_last   = (wr_idx_q == AW'(WINDOW - 1));

  // During a rescan the index and fill flag have already advanced past the new sample.
  assign scan_val  = (full_q || (rd_idx_q < wr_idx_q)) ? ram_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_idx_q    <= '0;
      full_q      <= 1'b0;
      scan_addr_q <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      sample_q    <= '0;
      held_min_q  <= '0;
      held_max_q  <= '0;
      out_vld_q   <= 1'b0;
      out_min_q   <= '0;
      out_max_q   <= '0;
    end else begin
      rd_vld_q <= (state_q == ST_SCAN);
      rd_idx_q <= scan_addr_q;

      if (push_fire) begin
        out_vld_q <= 1'b1;
        out_min_q <= held_min_q;
        out_max_q <= held_max_q;
      end else if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end

      if (rd_vld_q) begin
        if (scan_val < held_min_q) held_min_q <= scan_val;
        if (scan_val > held_max_q) held_max_q <= scan_val;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            sample_q <= in_i.sample;
            state_q  <= ST_EVICT;
          end
        end
        ST_EVICT: begin
          wr_idx_q <= wr_last ? '0 : wr_idx_q + 1'b1;
          if (wr_last) full_q <= 1'b1;
          if (need_scan) begin
            held_min_q  <= '1;
            held_max_q  <= '0;
            scan_addr_q <= '0;
            state_q     <= ST_SCAN;
          end else begin
            held_min_q <= new_min;
            held_max_q <= new_max;
            state_q    <= ST_PUSH;
          end
        end
        ST_SCAN: begin
          if (scan_addr_q == AW'(WINDOW - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            scan_addr_q <= scan_addr_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_PUSH;
        end
        ST_PUSH: begin
          if (push_fire) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.current_min = out_min_q;
  assign out_o.current_max = out_max_q;

  a_out_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.current_min <= out_o.current_max))
    else $error("result beat carries minimum above maximum");

  a_accept_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_EVICT))
    else $error("accepted beat did not move to the eviction step");

  a_scan_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (rd_vld_q && (rd_idx_q == AW'(WINDOW - 1))))
    else $error("rescan ended before the last ring entry was read");

endmodule
